// File: rtl/vue_pkg.sv
`default_nettype none
// ============================================================================
// vue_pkg
// Shared types and constants of the utterance endpointer: register indexes,
// register reset values, end reason codes and the item, result and status
// structures that pass between the modules.
// ============================================================================
package vue_pkg;

    // Field widths fixed by the stream format.
    localparam int PROB_W       = 16;
    localparam int TAIL_W       = 9;
    localparam int MS_W         = 16;
    localparam int PAD_W        = 12;
    localparam int CLIP_W       = 20;
    localparam int REASON_W     = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 96;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SPEECH_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CAPTURE_MS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_END_MS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_VOICED_MS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_MS           = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ONSET_TIMEOUT_MS = 3'd5;

    // Register values after reset.
    localparam logic [PROB_W-1:0] RST_SPEECH_THRESHOLD = 16'd32768;
    localparam logic [MS_W-1:0]   RST_MAX_CAPTURE_MS   = 16'd15000;
    localparam logic [MS_W-1:0]   RST_SILENCE_END_MS   = 16'd650;
    localparam logic [MS_W-1:0]   RST_MIN_VOICED_MS    = 16'd250;
    localparam logic [PAD_W-1:0]  RST_PAD_MS           = 12'd320;
    localparam logic [MS_W-1:0]   RST_ONSET_TIMEOUT_MS = 16'd8000;

    // End reason codes.
    localparam logic [REASON_W-1:0] REASON_NONE      = 3'd0;
    localparam logic [REASON_W-1:0] REASON_MAX_DUR   = 3'd1;
    localparam logic [REASON_W-1:0] REASON_SILENCE   = 3'd2;
    localparam logic [REASON_W-1:0] REASON_NO_SPEECH = 3'd3;
    localparam logic [REASON_W-1:0] REASON_END_INPUT = 3'd4;

    typedef struct packed {
        logic [PROB_W-1:0] speech_threshold;
        logic [MS_W-1:0]   max_capture_ms;
        logic [MS_W-1:0]   silence_end_ms;
        logic [MS_W-1:0]   min_voiced_ms;
        logic [PAD_W-1:0]  pad_ms;
        logic [MS_W-1:0]   onset_timeout_ms;
    } vue_cfg_t;

    typedef struct packed {
        logic              cmd;
        logic [PROB_W-1:0] speech_prob;
        logic [TAIL_W-1:0] tail_samples;
    } vue_item_t;

    typedef struct packed {
        logic                speech_start;
        logic                done_res;
        logic [REASON_W-1:0] end_reason;
        logic                speech_found;
        logic [MS_W-1:0]     total_ms;
        logic [MS_W-1:0]     voiced_ms;
        logic [CLIP_W-1:0]   clip_start;
        logic [CLIP_W-1:0]   clip_end;
        logic [MS_W-1:0]     clip_ms;
    } vue_result_t;

    typedef struct packed {
        logic finished;
        logic announced;
    } vue_status_t;

endpackage
`default_nettype wire

// File: rtl/vue_cfg_regs.sv
`default_nettype none
// ============================================================================
// vue_cfg_regs
// Configuration register file. Each register is written by index through a
// plain write port and is presented to the datapath as one structure.
// ============================================================================
module vue_cfg_regs
    import vue_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output vue_cfg_t                    cfg
);

    vue_cfg_t cfg_reg;
    vue_cfg_t cfg_next;

    // Decode the register index; indexes beyond the list change nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SPEECH_THRESHOLD: cfg_next.speech_threshold = wr_data;
                REG_MAX_CAPTURE_MS:   cfg_next.max_capture_ms   = wr_data;
                REG_SILENCE_END_MS:   cfg_next.silence_end_ms   = wr_data;
                REG_MIN_VOICED_MS:    cfg_next.min_voiced_ms    = wr_data;
                REG_PAD_MS:           cfg_next.pad_ms           = wr_data[PAD_W-1:0];
                REG_ONSET_TIMEOUT_MS: cfg_next.onset_timeout_ms = wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speech_threshold <= RST_SPEECH_THRESHOLD;
            cfg_reg.max_capture_ms   <= RST_MAX_CAPTURE_MS;
            cfg_reg.silence_end_ms   <= RST_SILENCE_END_MS;
            cfg_reg.min_voiced_ms    <= RST_MIN_VOICED_MS;
            cfg_reg.pad_ms           <= RST_PAD_MS;
            cfg_reg.onset_timeout_ms <= RST_ONSET_TIMEOUT_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: rtl/vue_core.sv
`default_nettype none
// ============================================================================
// vue_core
// Endpointing state and decision logic. Holds the window counters and the
// first and last speech windows, and from the registered input item forms
// the next state and the one result of that item in a single pass.
// ============================================================================
module vue_core
    import vue_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 512,
    parameter int COUNT_WIDTH    = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire vue_item_t item,
    input  wire vue_cfg_t  cfg,
    output vue_result_t    result,
    output vue_status_t    status
);

    localparam int WINDOW_MS = (1000 * WINDOW_SAMPLES) / 16000;
    localparam int WMS_W     = $clog2(WINDOW_MS + 1);
    localparam int WS_W      = $clog2(WINDOW_SAMPLES + 1);
    localparam int SPAN_W    = (COUNT_WIDTH + WS_W > CLIP_W) ? COUNT_WIDTH + WS_W : CLIP_W;
    localparam int TOTAL_W   = SPAN_W + 1;
    localparam int PROD_W    = (COUNT_WIDTH + WMS_W > MS_W) ? COUNT_WIDTH + WMS_W : MS_W;
    localparam int PRODX_W   = PROD_W + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] windows_seen_reg, windows_seen_next;
    logic [COUNT_WIDTH-1:0] speech_count_reg, speech_count_next;
    logic [COUNT_WIDTH-1:0] first_speech_reg, first_speech_next;
    logic [COUNT_WIDTH-1:0] last_speech_reg,  last_speech_next;
    logic                   first_valid_reg,  first_valid_next;
    logic                   announced_reg,    announced_next;
    logic                   finished_reg,     finished_next;

    logic                   is_window;
    logic                   is_speech;
    logic [TAIL_W-1:0]      tail_eff;
    logic [TOTAL_W-1:0]     total;
    logic [TOTAL_W-1:0]     limit_samples;
    logic [PRODX_W-1:0]     speech_prod;
    logic [PRODX_W-1:0]     gap_prod;
    logic [COUNT_WIDTH-1:0] gap;
    logic                   reached;
    logic [REASON_W-1:0]    reason;
    logic                   found;
    logic [TOTAL_W-1:0]     margin;
    logic [TOTAL_W-1:0]     lo_raw, hi_raw, lo, hi, diff;

    // Window bookkeeping for a scored window; end of input leaves it alone.
    always_comb
    begin
        is_window         = !item.cmd;
        is_speech         = is_window && (item.speech_prob >= cfg.speech_threshold);
        windows_seen_next = windows_seen_reg;
        speech_count_next = speech_count_reg;
        first_speech_next = first_speech_reg;
        last_speech_next  = last_speech_reg;
        first_valid_next  = first_valid_reg | is_speech;
        if (is_window)
        begin
            windows_seen_next = windows_seen_reg + COUNT_WIDTH'(1);
        end
        if (is_speech)
        begin
            // The speech count never passes the window count, which ends
            // the capture at its maximum, so the increment cannot wrap.
            speech_count_next = speech_count_reg + COUNT_WIDTH'(1);
            last_speech_next  = windows_seen_reg;
            if (!first_valid_reg)
            begin
                first_speech_next = windows_seen_reg;
            end
        end
        tail_eff = item.cmd ? item.tail_samples : '0;
    end

    // Sample count, speech time and trailing silence after this item.
    always_comb
    begin
        total = TOTAL_W'(windows_seen_next) * TOTAL_W'(WINDOW_SAMPLES)
              + TOTAL_W'(tail_eff);
        limit_samples = TOTAL_W'({cfg.max_capture_ms, 4'b0000});
        speech_prod = PRODX_W'(speech_count_next) * PRODX_W'(WINDOW_MS);
        reached     = speech_prod >= PRODX_W'(cfg.min_voiced_ms);
        gap         = windows_seen_next - COUNT_WIDTH'(1) - last_speech_next;
        gap_prod    = PRODX_W'(gap) * PRODX_W'(WINDOW_MS);
    end

    // End checks in priority order.
    always_comb
    begin
        priority if (total >= limit_samples || windows_seen_next == COUNT_MAX)
            reason = REASON_MAX_DUR;
        else if (reached && first_valid_next && windows_seen_next > last_speech_next
                 && gap_prod >= PRODX_W'(cfg.silence_end_ms))
            reason = REASON_SILENCE;
        else if (!reached && total[TOTAL_W-1:4] >= (TOTAL_W-4)'(cfg.onset_timeout_ms))
            reason = REASON_NO_SPEECH;
        else if (item.cmd)
            reason = reached ? REASON_END_INPUT : REASON_NO_SPEECH;
        else
            reason = REASON_NONE;
    end

    // Padded clip bounds around the first and last speech windows.
    always_comb
    begin
        margin      = TOTAL_W'({cfg.pad_ms, 4'b0000});
        lo_raw      = TOTAL_W'(first_speech_next) * TOTAL_W'(WINDOW_SAMPLES);
        hi_raw      = (TOTAL_W'(last_speech_next) + TOTAL_W'(1)) * TOTAL_W'(WINDOW_SAMPLES)
                    + margin;
        lo          = (lo_raw > margin) ? lo_raw - margin : '0;
        hi          = (hi_raw > total) ? total : hi_raw;
        diff        = (hi > lo) ? hi - lo : '0;
    end

    // Result of this item; everything after the end reads as zero.
    always_comb
    begin
        found  = reached && first_valid_next;
        result = '0;
        if (!finished_reg)
        begin
            result.speech_start = reached && !announced_reg;
            if (reason != REASON_NONE)
            begin
                result.done_res     = 1'b1;
                result.end_reason   = reason;
                result.speech_found = found;
                result.total_ms     = (|total[TOTAL_W-1:MS_W+4]) ? '1 : total[MS_W+3:4];
                result.voiced_ms    = (|speech_prod[PRODX_W-1:MS_W]) ? '1
                                    : speech_prod[MS_W-1:0];
                if (found)
                begin
                    result.clip_start = (|lo[TOTAL_W-1:CLIP_W]) ? '1 : lo[CLIP_W-1:0];
                    result.clip_end   = (|hi[TOTAL_W-1:CLIP_W]) ? '1 : hi[CLIP_W-1:0];
                    result.clip_ms    = (|diff[TOTAL_W-1:MS_W+4]) ? '1 : diff[MS_W+3:4];
                end
            end
        end
        announced_next = announced_reg | reached;
        finished_next  = reason != REASON_NONE;
    end

    // State advances only on a live capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            windows_seen_reg <= '0;
            speech_count_reg <= '0;
            first_speech_reg <= '0;
            last_speech_reg  <= '0;
            first_valid_reg  <= 1'b0;
            announced_reg    <= 1'b0;
            finished_reg     <= 1'b0;
        end
        else if (step && !finished_reg)
        begin
            windows_seen_reg <= windows_seen_next;
            speech_count_reg <= speech_count_next;
            first_speech_reg <= first_speech_next;
            last_speech_reg  <= last_speech_next;
            first_valid_reg  <= first_valid_next;
            announced_reg    <= announced_next;
            finished_reg     <= finished_next;
        end
    end

    assign status.finished  = finished_reg;
    assign status.announced = announced_reg;

endmodule
`default_nettype wire

// File: rtl/vad_utterance_endpointer_top.sv
`default_nettype none
// ============================================================================
// vad_utterance_endpointer_top
// Speech endpointer with hangover: one decision per scored window.
// ============================================================================
// The block takes one item per clock cycle on the input stream while the
// result stream does not stall, either a scored window (tuser low) or an
// end-of-input mark (tuser high), and gives exactly one result per item: the
// item waits in the input register and its result passes through the decision
// logic into the result register. The rate of one item per cycle is set by the
// single-pass update of the window counters, whose next value every later item reads.
// The result stream has tlast on the item that ends the capture, with the end
// reason in tuser; later items return all-zero results. There is no clearing
// pass after reset.
module vad_utterance_endpointer_top
    import vue_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 512,
    parameter int COUNT_WIDTH    = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port.
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    // Input stream.
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // speech_prob[15:0], tail_samples[24:16]
    input  wire logic                   s_tuser,   // cmd
    // Result stream.
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata,   // speech_start, speech_found,
                                                   // total_ms, voiced_ms, clip_start,
                                                   // clip_end, clip_ms
    output      logic [REASON_W-1:0]    m_tuser,   // end_reason
    output      logic                   m_tlast    // done_res
);

    vue_cfg_t    cfg;
    vue_item_t   item_reg;
    vue_result_t core_result;
    vue_result_t result_reg;
    vue_status_t status;
    logic        in_valid_reg, in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        advance;
    logic        in_xfer;
    logic        step;

    vue_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    vue_core #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result),
        .status (status)
    );

    // Pipeline flow: the input register moves on whenever the result
    // register is empty or its transfer completes this cycle.
    always_comb
    begin
        advance        = !out_valid_reg || m_tready;
        s_tready       = !in_valid_reg || advance;
        in_xfer        = s_tvalid && s_tready;
        step           = in_valid_reg && advance;
        in_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.cmd          <= s_tuser;
            item_reg.speech_prob  <= s_tdata[PROB_W-1:0];
            item_reg.tail_samples <= s_tdata[PROB_W+TAIL_W-1:PROB_W];
        end
        if (step)
        begin
            result_reg <= core_result;
        end
    end

    // Pack the result stream.
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = result_reg.done_res;
    assign m_tuser  = result_reg.end_reason;
    assign m_tdata  = {6'b000000,
                       result_reg.clip_ms,
                       result_reg.clip_end,
                       result_reg.clip_start,
                       result_reg.voiced_ms,
                       result_reg.total_ms,
                       result_reg.speech_found,
                       result_reg.speech_start};

    // A result that does not end the capture carries no reason and no verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == REASON_NONE && !m_tdata[1])
        else $error("non-final result carries an end reason or verdict");

    // The final result always names why the capture ended.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser != REASON_NONE)
        else $error("final result without an end reason");

    // Once ended, the capture stays ended until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.finished |=> status.finished)
        else $error("capture left the finished state");

    // Speech is announced no later than the capture ends with speech found.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && core_result.speech_found |-> status.announced || core_result.speech_start)
        else $error("speech found without a speech start");

endmodule
`default_nettype wire

// File: tb/tb_vad_utterance_endpointer_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_vad_utterance_endpointer_top
// Self-checking testbench for the utterance endpointer. A queue-fed driver
// offers scored windows and end-of-input marks on the input stream. An
// in-bench endpoint predictor computes the result of every transfer, and a
// monitor compares each result transfer field by field with the oldest
// prediction. The capture is held open through a long run of talk-like
// window sequences under changing thresholds, then closed by one of the end
// conditions, and followed by items that the block must ignore.
// ============================================================================
module tb_vad_utterance_endpointer_top;
    import vue_pkg::*;

    localparam longint unsigned WIN_SAMPLES    = 512;
    localparam longint unsigned WIN_MS         = 32;
    localparam longint unsigned SAMPLES_PER_MS = 16;
    localparam longint unsigned COUNT_MAX      = 65535;
    localparam longint unsigned MS_MAX         = 65535;
    localparam longint unsigned CLIP_MAX       = 20'hFFFFF;
    localparam logic            CMD_WINDOW     = 1'b0;
    localparam logic            CMD_END        = 1'b1;
    localparam int              HOLD_CYCLES    = 300;
    localparam int              SEGMENTS       = 8;
    localparam int              SEG_WINDOWS    = 128;
    localparam int              REPORT_MAX     = 10;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0]  wr_data  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [REASON_W-1:0]    m_tuser;
    logic                   m_tlast;

    // Items waiting to be offered, the item on the bus, and predicted results.
    vue_item_t   pending_items[$];
    vue_item_t   offered_item;
    vue_result_t awaited_results[$];

    // Predictor copy of the registers and of the capture state.
    vue_cfg_t cfg_model = '{speech_threshold: RST_SPEECH_THRESHOLD,
                            max_capture_ms:   RST_MAX_CAPTURE_MS,
                            silence_end_ms:   RST_SILENCE_END_MS,
                            min_voiced_ms:    RST_MIN_VOICED_MS,
                            pad_ms:           RST_PAD_MS,
                            onset_timeout_ms: RST_ONSET_TIMEOUT_MS};
    longint unsigned ep_windows   = 0;
    longint unsigned ep_speech    = 0;
    longint unsigned ep_first     = 0;
    longint unsigned ep_last      = 0;
    bit              ep_first_ok  = 1'b0;
    bit              ep_announced = 1'b0;
    bit              ep_finished  = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_ask       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int mismatches     = 0;

    vad_utterance_endpointer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic longint unsigned clamp_to(input longint unsigned v,
                                                 input longint unsigned m);
        return (v > m) ? m : v;
    endfunction

    // Advance the endpoint state by one item and return the result it causes.
    function automatic vue_result_t predict_endpoint(input vue_item_t it);
        vue_result_t         r;
        longint unsigned     total, tail, idx, pad, lo, hi;
        bit                  reached, found;
        logic [REASON_W-1:0] why;
        r = '0;
        if (ep_finished)
            return r;
        tail = 64'(it.tail_samples);
        if (it.cmd == CMD_WINDOW)
        begin
            idx = ep_windows;
            ep_windows = idx + 64'd1;
            if (it.speech_prob >= cfg_model.speech_threshold)
            begin
                ep_speech = clamp_to(ep_speech + 64'd1, COUNT_MAX);
                ep_last = idx;
                if (!ep_first_ok)
                begin
                    ep_first = idx;
                    ep_first_ok = 1'b1;
                end
            end
            tail = 64'd0;
        end
        total = ep_windows * WIN_SAMPLES + tail;
        reached = (ep_speech * WIN_MS) >= 64'(cfg_model.min_voiced_ms);

        if (reached && !ep_announced)
        begin
            ep_announced = 1'b1;
            r.speech_start = 1'b1;
        end

        // End conditions in priority order.
        why = REASON_NONE;
        if (total >= 64'(cfg_model.max_capture_ms) * SAMPLES_PER_MS
            || ep_windows >= COUNT_MAX)
            why = REASON_MAX_DUR;
        else if (reached && ep_first_ok && ep_windows > ep_last &&
                 (ep_windows - 64'd1 - ep_last) * WIN_MS >= 64'(cfg_model.silence_end_ms))
            why = REASON_SILENCE;
        else if (!reached && total / SAMPLES_PER_MS >= 64'(cfg_model.onset_timeout_ms))
            why = REASON_NO_SPEECH;
        else if (it.cmd == CMD_END)
            why = reached ? REASON_END_INPUT : REASON_NO_SPEECH;

        if (why != REASON_NONE)
        begin
            found = reached && ep_first_ok;
            ep_finished = 1'b1;
            r.done_res = 1'b1;
            r.end_reason = why;
            r.speech_found = found;
            r.total_ms = MS_W'(clamp_to(total / SAMPLES_PER_MS, MS_MAX));
            r.voiced_ms = MS_W'(clamp_to(ep_speech * WIN_MS, MS_MAX));
            if (found)
            begin
                pad = 64'(cfg_model.pad_ms) * SAMPLES_PER_MS;
                lo = ep_first * WIN_SAMPLES;
                hi = (ep_last + 64'd1) * WIN_SAMPLES + pad;
                lo = (lo > pad) ? lo - pad : 64'd0;
                if (hi > total)
                    hi = total;
                r.clip_start = CLIP_W'(clamp_to(lo, CLIP_MAX));
                r.clip_end = CLIP_W'(clamp_to(hi, CLIP_MAX));
                r.clip_ms = MS_W'(clamp_to((hi > lo) ? (hi - lo) / SAMPLES_PER_MS : 64'd0,
                                           MS_MAX));
            end
        end
        return r;
    endfunction

    // Driver: offers queued items and predicts each one at its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_results = {awaited_results, predict_endpoint(offered_item)};
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_TDATA_W - PROB_W - TAIL_W){1'b0}},
                                 offered_item.tail_samples, offered_item.speech_prob};
                    s_tuser  <= offered_item.cmd;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by the stimulus and timed here.
    always @(posedge clk)
    begin
        if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_field(input string fname, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // Monitor: compares every result transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        vue_result_t got, want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.speech_start = m_tdata[0];
                got.speech_found = m_tdata[1];
                got.total_ms     = m_tdata[17:2];
                got.voiced_ms    = m_tdata[33:18];
                got.clip_start   = m_tdata[53:34];
                got.clip_end     = m_tdata[73:54];
                got.clip_ms      = m_tdata[89:74];
                got.end_reason   = m_tuser;
                got.done_res     = m_tlast;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result transfer with no prediction waiting", $time);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("speech_start", 64'(want.speech_start), 64'(got.speech_start));
                    check_field("done_res", 64'(want.done_res), 64'(got.done_res));
                    check_field("end_reason", 64'(want.end_reason), 64'(got.end_reason));
                    check_field("speech_found", 64'(want.speech_found), 64'(got.speech_found));
                    check_field("total_ms", 64'(want.total_ms), 64'(got.total_ms));
                    check_field("voiced_ms", 64'(want.voiced_ms), 64'(got.voiced_ms));
                    check_field("clip_start", 64'(want.clip_start), 64'(got.clip_start));
                    check_field("clip_end", 64'(want.clip_end), 64'(got.clip_end));
                    check_field("clip_ms", 64'(want.clip_ms), 64'(got.clip_ms));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input logic cmd, input logic [PROB_W-1:0] prob,
                             input logic [TAIL_W-1:0] tail);
        vue_item_t it;
        it.cmd = cmd;
        it.speech_prob = prob;
        it.tail_samples = tail;
        pending_items = {pending_items, it};
    endtask

    // Probability on the chosen side of the current threshold, often right at it.
    function automatic logic [PROB_W-1:0] pick_prob(input bit speech);
        int unsigned thr;
        thr = 32'(cfg_model.speech_threshold);
        if (speech)
            return ($urandom_range(0, 7) == 0) ? PROB_W'(thr)
                                                : PROB_W'($urandom_range(65535, thr));
        else if (thr == 0)
            return '0;
        else
            return ($urandom_range(0, 7) == 0) ? PROB_W'(thr - 1)
                                                : PROB_W'($urandom_range(thr - 1, 0));
    endfunction

    // Talk-like window sequence: runs of speech and silence, with some noise.
    task automatic push_talk(input int n);
        int left, run;
        bit speech;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_item(CMD_WINDOW, PROB_W'($urandom), TAIL_W'($urandom));
                left--;
            end
            else
            begin
                speech = 1'($urandom_range(0, 1));
                run = $urandom_range(1, 24);
                if (run > left)
                    run = left;
                repeat (run) push_item(CMD_WINDOW, pick_prob(speech), TAIL_W'($urandom));
                left -= run;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en    <= 1'b0;
        case (idx)
            REG_SPEECH_THRESHOLD: cfg_model.speech_threshold = val;
            REG_MAX_CAPTURE_MS:   cfg_model.max_capture_ms = val;
            REG_SILENCE_END_MS:   cfg_model.silence_end_ms = val;
            REG_MIN_VOICED_MS:    cfg_model.min_voiced_ms = val;
            REG_PAD_MS:           cfg_model.pad_ms = val[PAD_W-1:0];
            REG_ONSET_TIMEOUT_MS: cfg_model.onset_timeout_ms = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Wait until every item has been transferred and every result has come.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_pad();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return CFG_DATA_W'(12'hFFF);
            default: return CFG_DATA_W'($urandom_range(0, 4095));
        endcase
    endfunction

    initial
    begin : stimulus
        int          seg;
        int          kind;
        int unsigned ms_now;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register reset values; windows below the default threshold.
        push_item(CMD_WINDOW, 16'd0, '0);
        push_item(CMD_WINDOW, 16'd1, '0);
        push_item(CMD_WINDOW, RST_SPEECH_THRESHOLD - PROB_W'(1), '0);
        wait_drained();

        // Zero minimum speech: speech counts as reached before any speech window.
        write_reg(REG_MIN_VOICED_MS, '0);
        push_item(CMD_WINDOW, 16'd0, '0);
        push_item(CMD_WINDOW, RST_SPEECH_THRESHOLD, '0);
        push_item(CMD_WINDOW, 16'hFFFF, '1);
        push_item(CMD_WINDOW, RST_SPEECH_THRESHOLD - PROB_W'(1), '0);
        wait_drained();

        // Threshold extremes: zero makes every window speech, full scale only the top.
        write_reg(REG_SPEECH_THRESHOLD, '0);
        push_item(CMD_WINDOW, 16'd0, '0);
        push_item(CMD_WINDOW, 16'h5555, '0);
        wait_drained();
        write_reg(REG_SPEECH_THRESHOLD, '1);
        push_item(CMD_WINDOW, 16'hFFFE, '0);
        push_item(CMD_WINDOW, 16'hFFFF, '0);
        push_item(CMD_WINDOW, 16'hAAAA, '0);
        wait_drained();

        // Keep the capture open through the long random part.
        write_reg(REG_MAX_CAPTURE_MS, '1);
        write_reg(REG_SILENCE_END_MS, '1);
        write_reg(REG_ONSET_TIMEOUT_MS, '1);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            write_reg(REG_SPEECH_THRESHOLD, (seg == 0) ? 16'hFFFF :
                                            (seg == 1) ? 16'h0000 :
                                            (seg == 6) ? 16'h0001 : PROB_W'($urandom));
            write_reg(REG_MIN_VOICED_MS, (seg == 2) ? 16'hFFFF :
                                         (seg == 3) ? 16'h0000 :
                                         CFG_DATA_W'($urandom_range(0, 4000)));
            write_reg(REG_PAD_MS, pick_pad());
            // The receiver holds off while the sender keeps offering.
            if (seg == 4)
                hold_ask++;
            push_talk(SEG_WINDOWS);
            wait_drained();
        end

        // Close the capture with one of the end conditions.
        send_idle_pct = 22;
        recv_stall_pct = 22;
        kind = $urandom_range(0, 3);
        ms_now = 32'(ep_windows * WIN_MS);
        write_reg(REG_PAD_MS, pick_pad());
        case (kind)
            0:
                push_item(CMD_END, PROB_W'($urandom),
                          ($urandom_range(0, 1) == 1) ? TAIL_W'(511) : TAIL_W'($urandom));
            1:
            begin
                write_reg(REG_MIN_VOICED_MS, '0);
                write_reg(REG_SILENCE_END_MS, CFG_DATA_W'($urandom_range(0, 400)));
                push_item(CMD_WINDOW, pick_prob(1'b1), '0);
                repeat (16) push_item(CMD_WINDOW, pick_prob(1'b0), '0);
            end
            2:
            begin
                write_reg(REG_MAX_CAPTURE_MS, CFG_DATA_W'($urandom_range(0, ms_now)));
                push_talk(4);
            end
            default:
            begin
                write_reg(REG_MIN_VOICED_MS, '1);
                write_reg(REG_ONSET_TIMEOUT_MS, CFG_DATA_W'($urandom_range(0, ms_now)));
                push_talk(4);
            end
        endcase

        // Items after the end are ignored and give all-zero results.
        repeat (30) push_item(1'($urandom_range(0, 1)), PROB_W'($urandom), TAIL_W'($urandom));
        push_item(CMD_END, '1, '1);
        push_item(CMD_WINDOW, '0, '0);
        wait_drained();
        repeat (8) @(negedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/vue_pkg.sv
rtl/vue_cfg_regs.sv
rtl/vue_core.sv
rtl/vad_utterance_endpointer_top.sv
tb/tb_vad_utterance_endpointer_top.sv
